/* sv/assert_macros.svh */
// Assertion macros for the RTL of the matrix multiply block.
// Each macro expects clk and rst_n in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLIES(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

/* sv/dmm_pkg.sv */
// Package for the double matrix multiply block: widths, codes, state types
// and the command/status structs between controller and datapath. No dependencies.
`timescale 1ns / 1ps
package dmm_pkg;

    localparam int MAX_DIM_DEF = 16;
    localparam int DATA_W      = 64;
    localparam int CMD_W       = 2;
    localparam int IDX_W       = 4;
    localparam int REG_W       = 5;
    localparam int CFG_IDX_W   = 2;
    localparam int S_TDATA_W   = 72;
    localparam int EXP_W       = 11;
    localparam int FRAC_W      = 52;
    localparam int MANT_W      = 53;
    localparam int HALF_W      = 27;
    localparam int GUARD_W     = 55;
    localparam int WIDE_W      = 109;

    localparam logic [REG_W-1:0]     REG_RESET     = 5'd16;
    localparam logic [CFG_IDX_W-1:0] REG_NUM_ROWS  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INNER_LEN = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_NUM_COLS  = 2'd2;

    localparam logic [DATA_W-1:0] QUIET_BIT   = 64'h0008_0000_0000_0000;
    localparam logic [DATA_W-1:0] DEFAULT_NAN = 64'hFFF8_0000_0000_0000;
    localparam logic [EXP_W-1:0]  EXP_MAX     = 11'h7FF;

    typedef enum logic [CMD_W-1:0] {
        CMD_WRITE_A = 2'd0,
        CMD_WRITE_B = 2'd1,
        CMD_COMPUTE = 2'd2,
        CMD_READ_C  = 2'd3
    } cmd_t;

    typedef enum logic {
        FPU_MUL = 1'b0,
        FPU_ADD = 1'b1
    } fpu_op_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_READ,
        ST_FETCH,
        ST_MUL,
        ST_MUL_WAIT,
        ST_ADD,
        ST_ADD_WAIT,
        ST_STORE
    } ctrl_state_t;

    typedef enum logic [2:0] {
        FS_IDLE,
        FS_MUL,
        FS_ADD_SUM,
        FS_OVF,
        FS_NORM,
        FS_DENORM,
        FS_ROUND,
        FS_DONE
    } fpu_state_t;

    typedef struct packed {
        logic    a_we;
        logic    b_we;
        logic    rd_c;
        logic    rd_err;
        logic    note_compute;
        logic    fetch;
        logic    fpu_start;
        fpu_op_t fpu_op;
        logic    prod_load;
        logic    acc_load;
        logic    acc_clear;
        logic    c_we;
        logic    out_load;
    } dp_cmd_t;

    typedef struct packed {
        logic fpu_done;
        logic out_busy;
    } dp_stat_t;

endpackage

/* sv/double_matrix_multiply.sv */
// Double-precision matrix multiply C = A*B, MAX_DIM x MAX_DIM stores of binary64.
// In-range write A/B requests are stored when accepted, and the block stays ready.
// A read of C reads the C store when accepted, then loads the output register in
// ST_READ once the output is free, and the next request is taken back in ST_IDLE;
// further requests are taken while a result waits. A compute request runs
// num_rows*inner_len*num_cols multiply-adds through the single shared multi-cycle
// floating-point unit. NaN or infinity operands, and zero operands of the multiply,
// skip the arithmetic, and renormalization runs stepwise. Each C element is then
// written in ST_STORE. Top level; depends on dmm_pkg, dmm_ctrl and dmm_datapath,
// which instantiates dmm_fpu.
`timescale 1ns / 1ps
module double_matrix_multiply #(
    parameter int MAX_DIM = dmm_pkg::MAX_DIM_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [dmm_pkg::S_TDATA_W-1:0]     s_tdata,   // row_index, col_index, element_bits
    input  logic [dmm_pkg::CMD_W-1:0]         s_tuser,   // command
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [dmm_pkg::DATA_W-1:0]        m_tdata,   // product_bits
    output logic [0:0]                        m_tuser,   // status
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [dmm_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [dmm_pkg::REG_W-1:0]         cfg_data
);
    import dmm_pkg::*;

    localparam int IXW = $clog2(MAX_DIM);
    localparam int DW  = $clog2(MAX_DIM + 1);

    dp_cmd_t  dp_cmd;
    dp_stat_t stat;
    logic [IXW-1:0] r_idx, c_idx, j_idx;
    logic [DW-1:0] rows, inner, cols;
    logic [IDX_W-1:0] in_row, in_col;
    logic [DATA_W-1:0] in_elem;
    logic status_bit;

    assign in_row    = s_tdata[IDX_W-1:0];
    assign in_col    = s_tdata[2*IDX_W-1:IDX_W];
    assign in_elem   = s_tdata[S_TDATA_W-1:2*IDX_W];
    assign cfg_ready = 1'b1;
    assign m_tuser   = status_bit;

    dmm_ctrl #(.MAX_DIM(MAX_DIM)) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .cmd      (cmd_t'(s_tuser)),
        .in_row   (in_row),
        .in_col   (in_col),
        .rows     (rows),
        .inner    (inner),
        .cols     (cols),
        .stat     (stat),
        .dp_cmd   (dp_cmd),
        .r_idx    (r_idx),
        .c_idx    (c_idx),
        .j_idx    (j_idx)
    );

    dmm_datapath #(.MAX_DIM(MAX_DIM)) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .dp_cmd    (dp_cmd),
        .stat      (stat),
        .in_row    (in_row),
        .in_col    (in_col),
        .in_elem   (in_elem),
        .r_idx     (r_idx),
        .c_idx     (c_idx),
        .j_idx     (j_idx),
        .cfg_we    (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .rows      (rows),
        .inner     (inner),
        .cols      (cols),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (status_bit)
    );

endmodule

/* sv/dmm_fpu.sv */
// Multi-cycle binary64 multiply / add unit, round-to-nearest-even.
// Iterative 27x27 partial products, stepwise normalization. Uses dmm_pkg.
`timescale 1ns / 1ps
module dmm_fpu (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  dmm_pkg::fpu_op_t       op,
    input  logic [dmm_pkg::DATA_W-1:0] opa,
    input  logic [dmm_pkg::DATA_W-1:0] opb,
    output logic                   done,
    output logic [dmm_pkg::DATA_W-1:0] result
);
    import dmm_pkg::*;

    localparam int WW  = WIDE_W;
    localparam int SHW = 7;
    localparam int XW  = 14;
    localparam logic signed [XW-1:0] XONE = 14'sd1;
    localparam logic [SHW-1:0] SH_MAX = 7'd108;

    fpu_state_t state_reg, state_next;
    logic sign_reg, sign_next, zsign_reg, zsign_next, sub_reg, sub_next;
    logic signed [XW-1:0] x_reg, x_next;
    logic [WW-1:0] m_reg, m_next, small_reg, small_next;
    logic [MANT_W-1:0] ma_reg, ma_next, mb_reg, mb_next;
    logic [2:0] step_reg, step_next;
    logic [2*HALF_W-1:0] pp_reg, pp_next;
    logic [DATA_W-1:0] res_reg, res_next;

    function automatic logic [WW-1:0] shr_sticky(input logic [WW-1:0] v,
                                                 input logic [SHW-1:0] sh);
        logic [WW-1:0] mask;
        logic [WW-1:0] q;
        mask = ~({WW{1'b1}} << sh);
        q = v >> sh;
        q[0] = q[0] | (|(v & mask));
        return q;
    endfunction

    // operand unpack
    logic sa, sb, a_nan, b_nan, a_inf, b_inf, a_zero, b_zero;
    logic [EXP_W-1:0] ea, eb, ea_eff, eb_eff;
    logic [MANT_W-1:0] ma_u, mb_u;
    assign sa     = opa[DATA_W-1];
    assign sb     = opb[DATA_W-1];
    assign ea     = opa[DATA_W-2:FRAC_W];
    assign eb     = opb[DATA_W-2:FRAC_W];
    assign a_nan  = (ea == EXP_MAX) && (opa[FRAC_W-1:0] != '0);
    assign b_nan  = (eb == EXP_MAX) && (opb[FRAC_W-1:0] != '0);
    assign a_inf  = (ea == EXP_MAX) && (opa[FRAC_W-1:0] == '0);
    assign b_inf  = (eb == EXP_MAX) && (opb[FRAC_W-1:0] == '0);
    assign a_zero = (opa[DATA_W-2:0] == '0);
    assign b_zero = (opb[DATA_W-2:0] == '0);
    assign ea_eff = (ea == '0) ? EXP_W'(1) : ea;
    assign eb_eff = (eb == '0) ? EXP_W'(1) : eb;
    assign ma_u   = {(ea != '0), opa[FRAC_W-1:0]};
    assign mb_u   = {(eb != '0), opb[FRAC_W-1:0]};

    // special operands
    logic mul_spec, add_spec;
    logic [DATA_W-1:0] mul_spec_val, add_spec_val;
    always_comb
    begin
        mul_spec     = 1'b1;
        mul_spec_val = '0;
        priority if (a_nan)
            mul_spec_val = opa | QUIET_BIT;
        else if (b_nan)
            mul_spec_val = opb | QUIET_BIT;
        else if ((a_inf && b_zero) || (a_zero && b_inf))
            mul_spec_val = DEFAULT_NAN;
        else if (a_inf || b_inf)
            mul_spec_val = {sa ^ sb, EXP_MAX, {FRAC_W{1'b0}}};
        else if (a_zero || b_zero)
            mul_spec_val = {sa ^ sb, {(DATA_W-1){1'b0}}};
        else
            mul_spec = 1'b0;

        add_spec     = 1'b1;
        add_spec_val = '0;
        priority if (a_nan)
            add_spec_val = opa | QUIET_BIT;
        else if (b_nan)
            add_spec_val = opb | QUIET_BIT;
        else if (a_inf && b_inf && (sa != sb))
            add_spec_val = DEFAULT_NAN;
        else if (a_inf)
            add_spec_val = opa;
        else if (b_inf)
            add_spec_val = opb;
        else
            add_spec = 1'b0;
    end

    // add alignment
    logic a_ge;
    logic [MANT_W-1:0] big_m, small_m;
    logic [EXP_W-1:0] big_e, small_e, ediff;
    logic [SHW-1:0] align_sh;
    logic [WW-1:0] aligned;
    always_comb
    begin
        a_ge     = (opa[DATA_W-2:0] >= opb[DATA_W-2:0]);
        big_m    = a_ge ? ma_u : mb_u;
        small_m  = a_ge ? mb_u : ma_u;
        big_e    = a_ge ? ea_eff : eb_eff;
        small_e  = a_ge ? eb_eff : ea_eff;
        ediff    = big_e - small_e;
        align_sh = (ediff > EXP_W'(SH_MAX)) ? SH_MAX : ediff[SHW-1:0];
        aligned  = shr_sticky({1'b0, small_m, {GUARD_W{1'b0}}}, align_sh);
    end

    // partial products
    logic [HALF_W-1:0] half_a, half_b;
    logic [5:0] pp_sh;
    assign half_a = step_reg[1] ? {1'b0, ma_reg[MANT_W-1:HALF_W]} : ma_reg[HALF_W-1:0];
    assign half_b = step_reg[0] ? {1'b0, mb_reg[MANT_W-1:HALF_W]} : mb_reg[HALF_W-1:0];
    always_comb
    begin
        unique case (step_reg)
            3'd1:    pp_sh = 6'd2;
            3'd2:    pp_sh = 6'd29;
            3'd3:    pp_sh = 6'd29;
            3'd4:    pp_sh = 6'd56;
            default: pp_sh = 6'd0;
        endcase
    end

    // normalize helpers
    logic [4:0] lz, lim, nsh;
    logic signed [XW-1:0] x_m1, x_neg;
    logic [SHW-1:0] den_sh;
    always_comb
    begin
        lz = 5'd16;
        for (int i = 0; i < 16; i++)
        begin
            if (m_reg[92 + i])
                lz = 5'(15 - i);
        end
        x_m1   = x_reg - XONE;
        lim    = (x_m1 < 14'sd16) ? x_m1[4:0] : 5'd16;
        nsh    = (lz < lim) ? lz : lim;
        x_neg  = XONE - x_reg;
        den_sh = (x_neg > 14'sd108) ? SH_MAX : x_neg[SHW-1:0];
    end

    // rounding
    logic [MANT_W-1:0] rmant;
    logic rinc;
    logic [MANT_W:0] rsum;
    logic signed [XW-1:0] xr;
    logic [DATA_W-1:0] rounded;
    always_comb
    begin
        rmant = m_reg[WW-2:GUARD_W];
        rinc  = m_reg[GUARD_W-1] & ((|m_reg[GUARD_W-2:0]) | rmant[0]);
        rsum  = {1'b0, rmant} + (MANT_W+1)'(rinc);
        xr    = x_reg + XW'(rsum[MANT_W]);
        if (m_reg == '0)
            rounded = {zsign_reg, {(DATA_W-1){1'b0}}};
        else if (xr >= 14'sd2047)
            rounded = {sign_reg, EXP_MAX, {FRAC_W{1'b0}}};
        else
            rounded = {sign_reg,
                       (rsum[MANT_W] | rsum[MANT_W-1]) ? xr[EXP_W-1:0] : {EXP_W{1'b0}},
                       rsum[MANT_W] ? {FRAC_W{1'b0}} : rsum[FRAC_W-1:0]};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= FS_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk)
    begin
        sign_reg  <= sign_next;
        zsign_reg <= zsign_next;
        sub_reg   <= sub_next;
        x_reg     <= x_next;
        m_reg     <= m_next;
        small_reg <= small_next;
        ma_reg    <= ma_next;
        mb_reg    <= mb_next;
        step_reg  <= step_next;
        pp_reg    <= pp_next;
        res_reg   <= res_next;
    end

    always_comb
    begin
        state_next = state_reg;
        sign_next  = sign_reg;
        zsign_next = zsign_reg;
        sub_next   = sub_reg;
        x_next     = x_reg;
        m_next     = m_reg;
        small_next = small_reg;
        ma_next    = ma_reg;
        mb_next    = mb_reg;
        step_next  = step_reg;
        pp_next    = pp_reg;
        res_next   = res_reg;
        done       = 1'b0;
        unique case (state_reg)
            FS_IDLE:
            begin
                if (start)
                begin
                    if (op == FPU_MUL)
                    begin
                        if (mul_spec)
                        begin
                            res_next   = mul_spec_val;
                            state_next = FS_DONE;
                        end
                        else
                        begin
                            ma_next    = ma_u;
                            mb_next    = mb_u;
                            sign_next  = sa ^ sb;
                            zsign_next = sa ^ sb;
                            x_next     = XW'(ea_eff) + XW'(eb_eff) - XW'(1022);
                            m_next     = '0;
                            step_next  = '0;
                            state_next = FS_MUL;
                        end
                    end
                    else
                    begin
                        if (add_spec)
                        begin
                            res_next   = add_spec_val;
                            state_next = FS_DONE;
                        end
                        else
                        begin
                            m_next     = {1'b0, big_m, {GUARD_W{1'b0}}};
                            small_next = aligned;
                            sub_next   = sa ^ sb;
                            sign_next  = a_ge ? sa : sb;
                            zsign_next = sa & sb;
                            x_next     = XW'(big_e);
                            state_next = FS_ADD_SUM;
                        end
                    end
                end
            end
            FS_MUL:
            begin
                pp_next   = half_a * half_b;
                step_next = step_reg + 3'd1;
                if (step_reg != 3'd0)
                    m_next = m_reg + (WW'(pp_reg) << pp_sh);
                if (step_reg == 3'd4)
                    state_next = FS_OVF;
            end
            FS_ADD_SUM:
            begin
                m_next     = sub_reg ? (m_reg - small_reg) : (m_reg + small_reg);
                state_next = FS_OVF;
            end
            FS_OVF:
            begin
                if (m_reg[WW-1])
                begin
                    m_next = shr_sticky(m_reg, SHW'(1));
                    x_next = x_reg + XONE;
                end
                state_next = FS_NORM;
            end
            FS_NORM:
            begin
                if (!m_reg[WW-2] && (x_reg > XONE) && (m_reg != '0))
                begin
                    m_next = m_reg << nsh;
                    x_next = x_reg - XW'(nsh);
                end
                else
                    state_next = FS_DENORM;
            end
            FS_DENORM:
            begin
                if (x_reg < XONE)
                begin
                    m_next = shr_sticky(m_reg, den_sh);
                    x_next = XONE;
                end
                state_next = FS_ROUND;
            end
            FS_ROUND:
            begin
                res_next   = rounded;
                state_next = FS_DONE;
            end
            FS_DONE:
            begin
                done       = 1'b1;
                state_next = FS_IDLE;
            end
            default:
                state_next = FS_IDLE;
        endcase
    end

    assign result = res_reg;

endmodule

/* sv/dmm_datapath.sv */
// Datapath: configuration registers, A/B/C memories, accumulator, output register.
// Driven by dmm_ctrl commands; instantiates dmm_fpu. Uses dmm_pkg.
`timescale 1ns / 1ps
module dmm_datapath #(
    parameter int MAX_DIM = dmm_pkg::MAX_DIM_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  dmm_pkg::dp_cmd_t                 dp_cmd,
    output dmm_pkg::dp_stat_t                stat,
    input  logic [dmm_pkg::IDX_W-1:0]        in_row,
    input  logic [dmm_pkg::IDX_W-1:0]        in_col,
    input  logic [dmm_pkg::DATA_W-1:0]       in_elem,
    input  logic [$clog2(MAX_DIM)-1:0]       r_idx,
    input  logic [$clog2(MAX_DIM)-1:0]       c_idx,
    input  logic [$clog2(MAX_DIM)-1:0]       j_idx,
    input  logic                             cfg_we,
    input  logic [dmm_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [dmm_pkg::REG_W-1:0]        cfg_data,
    output logic [$clog2(MAX_DIM+1)-1:0]     rows,
    output logic [$clog2(MAX_DIM+1)-1:0]     inner,
    output logic [$clog2(MAX_DIM+1)-1:0]     cols,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [dmm_pkg::DATA_W-1:0]       m_tdata,
    output logic                             m_tuser
);
    import dmm_pkg::*;

    localparam int DW    = $clog2(MAX_DIM + 1);
    localparam int DEPTH = MAX_DIM * MAX_DIM;
    localparam int AW    = $clog2(DEPTH);
    localparam int WAW   = AW + IDX_W + 1;

    logic [REG_W-1:0] rows_cfg_reg, inner_cfg_reg, cols_cfg_reg;

    function automatic logic [DW-1:0] eff_dim(input logic [REG_W-1:0] v);
        logic [DW-1:0] d;
        if (v == '0)
            d = DW'(1);
        else if (32'(v) > MAX_DIM)
            d = DW'(MAX_DIM);
        else
            d = DW'(v);
        return d;
    endfunction

    function automatic logic [AW-1:0] addr_of(input logic [WAW-1:0] r,
                                              input logic [WAW-1:0] c);
        logic [WAW-1:0] w;
        w = r * WAW'(MAX_DIM) + c;
        return w[AW-1:0];
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_cfg_reg  <= REG_RESET;
            inner_cfg_reg <= REG_RESET;
            cols_cfg_reg  <= REG_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_NUM_ROWS:  rows_cfg_reg  <= cfg_data;
                REG_INNER_LEN: inner_cfg_reg <= cfg_data;
                REG_NUM_COLS:  cols_cfg_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    assign rows  = eff_dim(rows_cfg_reg);
    assign inner = eff_dim(inner_cfg_reg);
    assign cols  = eff_dim(cols_cfg_reg);

    logic [AW-1:0] in_addr, a_addr, b_addr, c_addr;
    assign in_addr = addr_of(WAW'(in_row), WAW'(in_col));
    assign a_addr  = addr_of(WAW'(r_idx), WAW'(j_idx));
    assign b_addr  = addr_of(WAW'(j_idx), WAW'(c_idx));
    assign c_addr  = addr_of(WAW'(r_idx), WAW'(c_idx));

    logic [DATA_W-1:0] mem_a [DEPTH];
    logic [DATA_W-1:0] mem_b [DEPTH];
    logic [DATA_W-1:0] mem_c [DEPTH];
    logic [DATA_W-1:0] a_rdata_reg, b_rdata_reg, c_rdata_reg;
    logic [DATA_W-1:0] acc_reg, prod_reg, fpu_result;
    logic fpu_done;

    always_ff @(posedge clk)
    begin
        if (dp_cmd.a_we)
            mem_a[in_addr] <= in_elem;
        if (dp_cmd.fetch)
            a_rdata_reg <= mem_a[a_addr];
    end

    always_ff @(posedge clk)
    begin
        if (dp_cmd.b_we)
            mem_b[in_addr] <= in_elem;
        if (dp_cmd.fetch)
            b_rdata_reg <= mem_b[b_addr];
    end

    always_ff @(posedge clk)
    begin
        if (dp_cmd.c_we)
            mem_c[c_addr] <= acc_reg;
        if (dp_cmd.rd_c)
            c_rdata_reg <= mem_c[in_addr];
    end

    // extent of C written by the last compute; everything else reads as zero
    logic computed_reg;
    logic [DW-1:0] ext_rows_reg, ext_cols_reg;
    logic hit_reg, err_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            computed_reg <= 1'b0;
            ext_rows_reg <= '0;
            ext_cols_reg <= '0;
        end
        else if (dp_cmd.note_compute)
        begin
            computed_reg <= 1'b1;
            ext_rows_reg <= rows;
            ext_cols_reg <= cols;
        end
    end

    always_ff @(posedge clk)
    begin
        if (dp_cmd.rd_c)
        begin
            hit_reg <= computed_reg && (8'(in_row) < 8'(ext_rows_reg))
                       && (8'(in_col) < 8'(ext_cols_reg));
            err_reg <= dp_cmd.rd_err;
        end
    end

    always_ff @(posedge clk)
    begin
        if (dp_cmd.acc_clear)
            acc_reg <= '0;
        else if (dp_cmd.acc_load)
            acc_reg <= fpu_result;
        if (dp_cmd.prod_load)
            prod_reg <= fpu_result;
    end

    dmm_fpu u_fpu (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (dp_cmd.fpu_start),
        .op     (dp_cmd.fpu_op),
        .opa    ((dp_cmd.fpu_op == FPU_MUL) ? a_rdata_reg : acc_reg),
        .opb    ((dp_cmd.fpu_op == FPU_MUL) ? b_rdata_reg : prod_reg),
        .done   (fpu_done),
        .result (fpu_result)
    );

    logic m_tvalid_reg, m_tuser_reg;
    logic [DATA_W-1:0] m_tdata_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tvalid_reg <= 1'b0;
        else if (dp_cmd.out_load)
            m_tvalid_reg <= 1'b1;
        else if (m_tready)
            m_tvalid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (dp_cmd.out_load)
        begin
            m_tdata_reg <= (err_reg || !hit_reg) ? '0 : c_rdata_reg;
            m_tuser_reg <= err_reg;
        end
    end

    assign m_tvalid      = m_tvalid_reg;
    assign m_tdata       = m_tdata_reg;
    assign m_tuser       = m_tuser_reg;
    assign stat.fpu_done = fpu_done;
    assign stat.out_busy = m_tvalid_reg && !m_tready;

endmodule

/* sv/dmm_ctrl.sv */
// Controller state machine: decodes requests, sequences the r/c/j compute loops.
// Drives dmm_datapath through dp_cmd_t. Uses dmm_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module dmm_ctrl #(
    parameter int MAX_DIM = dmm_pkg::MAX_DIM_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  dmm_pkg::cmd_t                 cmd,
    input  logic [dmm_pkg::IDX_W-1:0]     in_row,
    input  logic [dmm_pkg::IDX_W-1:0]     in_col,
    input  logic [$clog2(MAX_DIM+1)-1:0]  rows,
    input  logic [$clog2(MAX_DIM+1)-1:0]  inner,
    input  logic [$clog2(MAX_DIM+1)-1:0]  cols,
    input  dmm_pkg::dp_stat_t             stat,
    output dmm_pkg::dp_cmd_t              dp_cmd,
    output logic [$clog2(MAX_DIM)-1:0]    r_idx,
    output logic [$clog2(MAX_DIM)-1:0]    c_idx,
    output logic [$clog2(MAX_DIM)-1:0]    j_idx
);
    import dmm_pkg::*;

    localparam int IXW = $clog2(MAX_DIM);
    localparam int DW  = $clog2(MAX_DIM + 1);

    ctrl_state_t state_reg, state_next;
    logic [IXW-1:0] r_reg, r_next, c_reg, c_next, j_reg, j_next;
    logic s_accept, row_lt_rows, row_lt_inner, col_lt_inner, col_lt_cols;

    assign s_accept     = s_tvalid && s_tready;
    assign row_lt_rows  = 8'(in_row) < 8'(rows);
    assign row_lt_inner = 8'(in_row) < 8'(inner);
    assign col_lt_inner = 8'(in_col) < 8'(inner);
    assign col_lt_cols  = 8'(in_col) < 8'(cols);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            r_reg     <= '0;
            c_reg     <= '0;
            j_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            r_reg     <= r_next;
            c_reg     <= c_next;
            j_reg     <= j_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        r_next     = r_reg;
        c_next     = c_reg;
        j_next     = j_reg;
        dp_cmd     = '0;
        dp_cmd.fpu_op = FPU_MUL;
        s_tready   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_accept)
                begin
                    unique case (cmd)
                        CMD_WRITE_A:
                            dp_cmd.a_we = row_lt_rows && col_lt_inner;
                        CMD_WRITE_B:
                            dp_cmd.b_we = row_lt_inner && col_lt_cols;
                        CMD_COMPUTE:
                        begin
                            dp_cmd.note_compute = 1'b1;
                            dp_cmd.acc_clear    = 1'b1;
                            r_next     = '0;
                            c_next     = '0;
                            j_next     = '0;
                            state_next = ST_FETCH;
                        end
                        CMD_READ_C:
                        begin
                            dp_cmd.rd_c   = 1'b1;
                            dp_cmd.rd_err = !(row_lt_rows && col_lt_cols);
                            state_next    = ST_READ;
                        end
                        default: ;
                    endcase
                end
            end
            ST_READ:
            begin
                if (!stat.out_busy)
                begin
                    dp_cmd.out_load = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            ST_FETCH:
            begin
                dp_cmd.fetch = 1'b1;
                state_next   = ST_MUL;
            end
            ST_MUL:
            begin
                dp_cmd.fpu_start = 1'b1;
                state_next       = ST_MUL_WAIT;
            end
            ST_MUL_WAIT:
            begin
                if (stat.fpu_done)
                begin
                    dp_cmd.prod_load = 1'b1;
                    state_next       = ST_ADD;
                end
            end
            ST_ADD:
            begin
                dp_cmd.fpu_op    = FPU_ADD;
                dp_cmd.fpu_start = 1'b1;
                state_next       = ST_ADD_WAIT;
            end
            ST_ADD_WAIT:
            begin
                dp_cmd.fpu_op = FPU_ADD;
                if (stat.fpu_done)
                begin
                    dp_cmd.acc_load = 1'b1;
                    if ((DW'(j_reg) + DW'(1)) == inner)
                        state_next = ST_STORE;
                    else
                    begin
                        j_next     = j_reg + IXW'(1);
                        state_next = ST_FETCH;
                    end
                end
            end
            ST_STORE:
            begin
                dp_cmd.c_we      = 1'b1;
                dp_cmd.acc_clear = 1'b1;
                j_next           = '0;
                state_next       = ST_FETCH;
                if ((DW'(c_reg) + DW'(1)) == cols)
                begin
                    c_next = '0;
                    if ((DW'(r_reg) + DW'(1)) == rows)
                        state_next = ST_IDLE;
                    else
                        r_next = r_reg + IXW'(1);
                end
                else
                    c_next = c_reg + IXW'(1);
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    assign r_idx = r_reg;
    assign c_idx = c_reg;
    assign j_idx = j_reg;

    `ASSERT_NEXT(a_read_waits, s_accept && (cmd == CMD_READ_C), state_reg == ST_READ)
    `ASSERT_NEXT(a_start_waits, dp_cmd.fpu_start,
                 (state_reg == ST_MUL_WAIT) || (state_reg == ST_ADD_WAIT))
    `ASSERT_IMPLIES(a_store_after_add, state_reg == ST_STORE,
                    $past(state_reg) == ST_ADD_WAIT)
    `ASSERT_IMPLIES(a_load_when_free, dp_cmd.out_load, !stat.out_busy)

endmodule
